/* hdl/srpq_pkg.sv */
package srpq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Word fields
  localparam int ID_W    = 32;
  localparam int PRI_W   = 8;
  localparam int STAT_W  = 2;
  localparam int ENTRY_W = ID_W + PRI_W;

  // Commands
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
    cnt_t              occ;
  } result_t;

  // Ring slot one step toward the head
  function automatic idx_t slot_before(idx_t s);
    idx_t r;
    if (s == '0) begin
      r = idx_t'(QUEUE_DEPTH - 1);
    end else begin
      r = s - idx_t'(1);
    end
    return r;
  endfunction

  // Ring slot one step toward the tail
  function automatic idx_t slot_after(idx_t s);
    idx_t r;
    if (s == idx_t'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + idx_t'(1);
    end
    return r;
  endfunction

endpackage

/* hdl/srpq_ram.sv */
module srpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/srpq_ctrl.sv */
module srpq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [srpq_pkg::ID_W-1:0]     in_id,
  input  logic [srpq_pkg::PRI_W-1:0]    in_priority,
  output logic                          res_valid,
  input  logic                          res_ready,
  output srpq_pkg::result_t             res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_DEQ  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  srpq_pkg::idx_t    head_r, head_nxt;
  srpq_pkg::idx_t    tail_r, tail_nxt;
  srpq_pkg::cnt_t    count_r, count_nxt;
  srpq_pkg::idx_t    pos_r, pos_nxt;
  srpq_pkg::entry_t  new_r, new_nxt;
  srpq_pkg::result_t res_r, res_nxt;

  logic                          wr_en;
  srpq_pkg::idx_t                wr_addr;
  srpq_pkg::entry_t              wr_entry;
  srpq_pkg::idx_t                rd_addr;
  logic [srpq_pkg::ENTRY_W-1:0]  rd_data;
  srpq_pkg::entry_t              rd_entry;
  srpq_pkg::idx_t                prev_slot;
  logic                          accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;
  assign rd_entry  = srpq_pkg::entry_t'(rd_data);
  assign prev_slot = srpq_pkg::slot_before(pos_r);

  // Entry store
  srpq_ram #(
    .WIDTH (srpq_pkg::ENTRY_W),
    .DEPTH (srpq_pkg::QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (1'b1),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Read address: head for a dequeue, else the slot ahead of the entry's next position
  always_comb begin
    if (state_r == S_IDLE) begin
      rd_addr = (in_cmd == srpq_pkg::CMD_DEQ) ? head_r : srpq_pkg::slot_before(tail_r);
    end else begin
      rd_addr = srpq_pkg::slot_before(prev_slot);
    end
  end

  // Sequencer: insertion walk and dequeue
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    new_nxt   = new_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    wr_addr   = pos_r;
    wr_entry  = new_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt.id  = '0;
          res_nxt.pri = '0;
          if (in_cmd == srpq_pkg::CMD_ENQ) begin
            if (count_r == srpq_pkg::cnt_t'(srpq_pkg::QUEUE_DEPTH)) begin
              res_nxt.status = srpq_pkg::ST_FULL;
              res_nxt.occ    = count_r;
              state_nxt      = S_DONE;
            end else begin
              new_nxt.id     = in_id;
              new_nxt.pri    = in_priority;
              pos_nxt        = tail_r;
              tail_nxt       = srpq_pkg::slot_after(tail_r);
              count_nxt      = count_r + srpq_pkg::cnt_t'(1);
              res_nxt.status = srpq_pkg::ST_OK;
              res_nxt.occ    = count_r + srpq_pkg::cnt_t'(1);
              if (count_r == '0) begin
                // Empty queue: drop the word straight into the tail slot
                wr_en        = 1'b1;
                wr_addr      = tail_r;
                wr_entry.id  = in_id;
                wr_entry.pri = in_priority;
                state_nxt    = S_DONE;
              end else begin
                state_nxt = S_CMP;
              end
            end
          end else begin
            if (count_r == '0) begin
              res_nxt.status = srpq_pkg::ST_EMPTY;
              res_nxt.occ    = '0;
              state_nxt      = S_DONE;
            end else begin
              head_nxt       = srpq_pkg::slot_after(head_r);
              count_nxt      = count_r - srpq_pkg::cnt_t'(1);
              res_nxt.status = srpq_pkg::ST_OK;
              res_nxt.occ    = count_r - srpq_pkg::cnt_t'(1);
              state_nxt      = S_DEQ;
            end
          end
        end
      end
      S_CMP: begin
        wr_en = 1'b1;
        if (new_r.pri > rd_entry.pri) begin
          // Shift the lower-priority entry back one slot and advance
          wr_entry = rd_entry;
          pos_nxt  = prev_slot;
          if (prev_slot == head_r) begin
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FIN: begin
        wr_en     = 1'b1;
        state_nxt = S_DONE;
      end
      S_DEQ: begin
        res_nxt.id  = rd_entry.id;
        res_nxt.pri = rd_entry.pri;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload holding registers
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    new_r <= new_nxt;
    res_r <= res_nxt;
  end

endmodule

/* hdl/sorted_ring_priority_queue.sv */
// Channel  | Handshake              | Word
// ---------+------------------------+-------------------------------------------------
// input    | in_valid / in_ready    | in_cmd, in_id, in_priority
// result   | out_valid / out_ready  | out_status, out_id, out_priority, out_occupancy
//
// One word in gives one word out. Error returns and an enqueue into an empty queue
// go straight to the result; a dequeue first reads the head word, and an enqueue
// walks past each entry of lower priority, one slot shift per cycle, as the single
// read port of the entry RAM allows. Reset is synchronous; the RAM holds no reset.
// A result waiting in the output register does not block the next input word.
module sorted_ring_priority_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [srpq_pkg::ID_W-1:0]     in_id,
  input  logic [srpq_pkg::PRI_W-1:0]    in_priority,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srpq_pkg::STAT_W-1:0]   out_status,
  output logic [srpq_pkg::ID_W-1:0]     out_id,
  output logic [srpq_pkg::PRI_W-1:0]    out_priority,
  output logic [srpq_pkg::CNT_W-1:0]    out_occupancy
);

  logic              res_valid;
  logic              res_ready;
  srpq_pkg::result_t res;
  logic              out_valid_r, out_valid_nxt;
  srpq_pkg::result_t out_r, out_nxt;

  srpq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_id       (in_id),
    .in_priority (in_priority),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_r.status;
  assign out_id        = out_r.id;
  assign out_priority  = out_r.pri;
  assign out_occupancy = out_r.occ;

  // A full report always shows a full queue
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == srpq_pkg::ST_FULL
      |-> out_occupancy == srpq_pkg::CNT_W'(srpq_pkg::QUEUE_DEPTH))
    else $error("full status with occupancy below depth");

  // An empty report carries no entry and no occupancy
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == srpq_pkg::ST_EMPTY
      |-> out_occupancy == '0 && out_id == '0 && out_priority == '0)
    else $error("empty status with nonzero word");

  // Occupancy never exceeds the queue depth
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= srpq_pkg::CNT_W'(srpq_pkg::QUEUE_DEPTH))
    else $error("occupancy above depth");

  // One word at a time in the sequencer
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in flight");

endmodule

/* bench/srpq_order_check.sv */
`timescale 1ns / 1ps

module srpq_order_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [srpq_pkg::ID_W-1:0]     in_id,
  input  logic [srpq_pkg::PRI_W-1:0]    in_priority,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [srpq_pkg::STAT_W-1:0]   out_status,
  input  logic [srpq_pkg::ID_W-1:0]     out_id,
  input  logic [srpq_pkg::PRI_W-1:0]    out_priority,
  input  logic [srpq_pkg::CNT_W-1:0]    out_occupancy,
  output int                            fail_count,
  output int                            pending_results
);

  import srpq_pkg::*;

  // Shadow copy of the ring and its pointers
  logic [ID_W-1:0]  shadow_id  [QUEUE_DEPTH];
  logic [PRI_W-1:0] shadow_pri [QUEUE_DEPTH];
  int               shadow_head;
  int               shadow_tail;
  int               shadow_count;

  // Results still owed by the block, oldest first
  result_t          awaited_results[$];

  // Clear the shadow queue to its post-reset state
  task automatic clear_shadow();
    for (int s = 0; s < QUEUE_DEPTH; s++) begin
      shadow_id[s]  = '0;
      shadow_pri[s] = '0;
    end
    shadow_head  = 0;
    shadow_tail  = 0;
    shadow_count = 0;
  endtask

  // Apply one command to the shadow queue and return the word it must produce
  function automatic result_t apply_queue_cmd(logic cmd, logic [ID_W-1:0] id,
                                              logic [PRI_W-1:0] pri);
    result_t          res;
    int               pos;
    int               prev;
    logic [ID_W-1:0]  swap_id;
    logic [PRI_W-1:0] swap_pri;
    res = '0;
    if (cmd == CMD_ENQ) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // place at the tail, then bubble toward the head past lower priorities
        pos = shadow_tail;
        shadow_id[pos]  = id;
        shadow_pri[pos] = pri;
        while (pos != shadow_head) begin
          prev = (pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
          if (!(shadow_pri[pos] > shadow_pri[prev])) break;
          swap_id          = shadow_id[pos];
          swap_pri         = shadow_pri[pos];
          shadow_id[pos]   = shadow_id[prev];
          shadow_pri[pos]  = shadow_pri[prev];
          shadow_id[prev]  = swap_id;
          shadow_pri[prev] = swap_pri;
          pos = prev;
        end
        shadow_tail  = (shadow_tail + 1) % QUEUE_DEPTH;
        shadow_count = shadow_count + 1;
        res.status   = ST_OK;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.status   = ST_OK;
        res.id       = shadow_id[shadow_head];
        res.pri      = shadow_pri[shadow_head];
        shadow_head  = (shadow_head + 1) % QUEUE_DEPTH;
        shadow_count = shadow_count - 1;
      end
    end
    res.occ = cnt_t'(shadow_count);
    return res;
  endfunction

  // Compare an accepted result word with the oldest one owed
  task automatic check_result_word();
    result_t want;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result word status=%0d id=%h pri=%0d occ=%0d",
               $time, out_status, out_id, out_priority, out_occupancy);
      fail_count++;
    end else begin
      want = awaited_results.pop_front();
      if (out_status !== want.status || out_id !== want.id ||
          out_priority !== want.pri || out_occupancy !== want.occ) begin
        $display("%0t: result mismatch expected status=%0d id=%h pri=%0d occ=%0d",
                 $time, want.status, want.id, want.pri, want.occ);
        $display("%0t:                 actual   status=%0d id=%h pri=%0d occ=%0d",
                 $time, out_status, out_id, out_priority, out_occupancy);
        fail_count++;
      end
    end
  endtask

  // Retire outputs before predicting, so a same-edge input never matches its own word
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_shadow();
      awaited_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result_word();
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_queue_cmd(in_cmd, in_id, in_priority));
      end
    end
    pending_results = awaited_results.size();
  end

endmodule

/* bench/sorted_ring_priority_queue_test.sv */
`timescale 1ns / 1ps

module sorted_ring_priority_queue_test;

  import srpq_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_cmd;
  logic [ID_W-1:0]   in_id;
  logic [PRI_W-1:0]  in_priority;
  logic              out_valid;
  logic              out_ready;
  logic [STAT_W-1:0] out_status;
  logic [ID_W-1:0]   out_id;
  logic [PRI_W-1:0]  out_priority;
  logic [CNT_W-1:0]  out_occupancy;

  int                fail_count;
  int                pending_results;
  logic              send_idle_on;
  logic              recv_stall_on;

  sorted_ring_priority_queue uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_id         (in_id),
    .in_priority   (in_priority),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_id        (out_id),
    .out_priority  (out_priority),
    .out_occupancy (out_occupancy)
  );

  srpq_order_check order_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_id           (in_id),
    .in_priority     (in_priority),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_id          (out_id),
    .out_priority    (out_priority),
    .out_occupancy   (out_occupancy),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result side: if stalls are on, wait a random number of cycles before taking each word
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = recv_stall_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offer one word after a random gap and hold it until taken; returns at a falling edge
  task automatic send_word(logic cmd, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_id       <= id;
    in_priority <= pri;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // Hold off input until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
  endtask

  // Draw a priority according to the burst's flavor
  function automatic logic [PRI_W-1:0] draw_priority(int flavor);
    logic [PRI_W-1:0] p;
    case (flavor)
      0: p = PRI_W'($urandom_range(0, 3));
      1: p = PRI_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: p = 8'd0;
          1: p = 8'd255;
          2: p = 8'd1;
          default: p = 8'd254;
        endcase
      end
    endcase
    return p;
  endfunction

  initial begin
    int               sent;
    int               burst_len;
    int               enq_pct;
    int               pri_flavor;
    logic             pressure_done;
    logic             cmd;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;

    in_valid      = 1'b0;
    in_cmd        = CMD_ENQ;
    in_id         = '0;
    in_priority   = '0;
    rst_n         = 1'b0;
    send_idle_on  = 1'b0;
    recv_stall_on = 1'b0;
    pressure_done = 1'b0;

    // Hold reset, then release it at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Dequeue on empty, with payload fields set that must be ignored
    send_word(CMD_DEQ, 32'hFFFF_FFFF, 8'hFF);
    // Field extremes and priority ties at both ends and in the middle
    send_word(CMD_ENQ, 32'h0000_0000, 8'd0);
    send_word(CMD_ENQ, 32'hFFFF_FFFF, 8'd255);
    send_word(CMD_ENQ, 32'h0000_0001, 8'd128);
    send_word(CMD_ENQ, 32'h0000_0002, 8'd128);
    send_word(CMD_ENQ, 32'h0000_0003, 8'd255);
    send_word(CMD_ENQ, 32'h0000_0004, 8'd0);
    // Fill to capacity
    for (int i = 0; i < QUEUE_DEPTH - 6; i++) begin
      send_word(CMD_ENQ, 32'h1000_0000 + i, PRI_W'(i * 23));
    end
    // Enqueue into a full queue
    send_word(CMD_ENQ, 32'hA5A5_5A5A, 8'd255);
    // Pull a few from the head
    for (int i = 0; i < 5; i++) begin
      send_word(CMD_DEQ, 32'h5A5A_A5A5, 8'hAA);
    end
    wait_drained();

    // Random bursts that swing the queue between empty and full
    sent = 0;
    while (sent < 1500) begin
      burst_len  = $urandom_range(40, 80);
      case ($urandom_range(0, 2))
        0: enq_pct = 15;
        1: enq_pct = 50;
        default: enq_pct = 85;
      endcase
      pri_flavor    = $urandom_range(0, 2);
      send_idle_on  = ($urandom_range(0, 2) != 0);
      recv_stall_on = ($urandom_range(0, 2) != 0);
      if (!pressure_done && sent >= 700) begin
        wait_drained();
        pressure_done = 1'b1;
      end
      for (int i = 0; i < burst_len; i++) begin
        cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
        id  = $urandom;
        pri = draw_priority(pri_flavor);
        send_word(cmd, id, pri);
      end
      sent += burst_len;
    end

    // Drain and let any straggler word show up
    wait_drained();
    repeat (25) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
